// ===== sv/ads_pkg.sv =====
package ads_pkg;

    // Field widths of the point and result requests.
    localparam int COORD_W   = 18;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int RANGE_W   = 17;
    localparam int ANGLE_W   = 16;
    localparam int GAP_W     = 16;
    localparam int CLUSTER_W = 12;
    localparam int SINE_W    = 15;
    localparam int THR_W     = 18;

    // Defaults and limits.
    localparam int SCAN_POINTS      = 2048;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [GAP_W-1:0]     GAP_RESET   = 16'd500;
    localparam logic [THR_W-1:0]     THR_MAX     = 18'h3FFFF;
    localparam logic [CLUSTER_W-1:0] CLUSTER_CAP =
        CLUSTER_W'((SCAN_POINTS < 4095) ? SCAN_POINTS : 4095);

    // Pi/2 in Q30, the angle scale of the sine generator.
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Step description handed from the front end to the back end.
    typedef struct packed {
        logic                     first;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [RANGE_W-1:0]       min_range;
    } ads_step_t;

    // Divides a Taylor term by (2n)(2n+1), the factorial step of the n-th term.
    function automatic longint taylor_div(longint v, int n);
        longint q;
        unique case (n)
            1:       q = v / 6;
            2:       q = v / 20;
            3:       q = v / 42;
            4:       q = v / 72;
            5:       q = v / 110;
            6:       q = v / 156;
            7:       q = v / 210;
            8:       q = v / 272;
            9:       q = v / 342;
            10:      q = v / 420;
            11:      q = v / 506;
            12:      q = v / 600;
            13:      q = v / 702;
            14:      q = v / 812;
            15:      q = v / 930;
            16:      q = v / 1056;
            17:      q = v / 1190;
            18:      q = v / 1332;
            19:      q = v / 1482;
            default: q = v / 1640;
        endcase
        return q;
    endfunction

    // One sine table entry in unsigned Q0.15 for an angle in Q30, by Taylor series.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [SINE_W-1:0] sine_entry(longint a);
        longint a2;
        longint term;
        longint sum;
        longint e;
        logic   done;
        a2   = (a * a) >>> 30;
        term = a;
        sum  = a;
        done = 1'b0;
        for (int n = 1; n <= 20; n++)
        begin
            if (!done)
            begin
                term = taylor_div((term * a2) >>> 30, n);
                if (term == 0)
                    done = 1'b1;
                else if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        if (sum < 0)
            sum = 0;
        e = (sum * 32768 + (64'sd1 <<< 29)) >>> 30;
        if (e > 32767)
            e = 32767;
        return SINE_W'(e);
    endfunction

endpackage

// ===== sv/ads_if.sv =====
// Point request channel.
interface ads_point_if;
    import ads_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x_mm;
    logic signed [COORD_W-1:0] point_y_mm;
    logic [RANGE_W-1:0]        range_mm;
    logic [ANGLE_W-1:0]        angle_units;
    logic                      scan_start;

    modport source (output valid, point_x_mm, point_y_mm, range_mm, angle_units,
                    scan_start, input ready);
    modport sink   (input valid, point_x_mm, point_y_mm, range_mm, angle_units,
                    scan_start, output ready);
endinterface

// Cluster result channel.
interface ads_cluster_if;
    import ads_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CLUSTER_W-1:0] cluster_number;
    logic                 opens_cluster;

    modport source (output valid, cluster_number, opens_cluster, input ready);
    modport sink   (input valid, cluster_number, opens_cluster, output ready);
endinterface

// ===== sv/adaptive_distance_scan_segmenter.sv =====
// Adaptive distance scan segmenter. Laser points enter on the points channel in scan
// order and each one leaves on the clusters channel with its cluster number and a
// flag that marks the first point of a cluster. A break opens when the squared step
// to the previous point exceeds the square of base_gap_mm plus 2|sin(dtheta/2)| times
// the smaller of the two ranges. The front end takes one point per cycle while its
// four-entry queue has room; the back end does a table read, four products on one
// shared 20x20 multiplier, a compare and the result, and pops the next point only
// once the current one is in the result register, which holds it while the next is
// processed. A scan's first point skips the arithmetic. The user must write the
// threshold register (cfg_we / cfg_wdata) while idle; the block does not enforce it.
module adaptive_distance_scan_segmenter
    import ads_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = ads_pkg::SINE_TABLE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [GAP_W-1:0] cfg_wdata,
    ads_point_if.sink        points,
    ads_cluster_if.source    clusters
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int STEP_W = $bits(ads_step_t);
    localparam int DATA_W = STEP_W + IDX_W;

    ads_step_t          step;
    logic [IDX_W-1:0]   step_idx;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [DATA_W-1:0]  pop_data;
    ads_step_t          head_step;
    logic [IDX_W-1:0]   head_idx;

    assign head_step = pop_data[STEP_W-1:0];
    assign head_idx  = pop_data[DATA_W-1:STEP_W];

    ads_front #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .IDX_W            (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .full     (full),
        .push     (push),
        .step     (step),
        .step_idx (step_idx)
    );

    ads_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({step_idx, step}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ads_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .IDX_W            (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .empty     (empty),
        .head_step (head_step),
        .head_idx  (head_idx),
        .pop       (pop),
        .clusters  (clusters)
    );

endmodule

// ===== sv/ads_fifo.sv =====
module ads_fifo
    import ads_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [DATA_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full     = (count_reg == (PTR_W + 1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Storage is written only when a request enters.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/ads_front.sv =====
module ads_front
    import ads_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = ads_pkg::SINE_TABLE_DEPTH,
    parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    ads_point_if.sink        points,
    input  logic             full,
    output logic             push,
    output ads_step_t        step,
    output logic [IDX_W-1:0] step_idx
);

    logic signed [COORD_W-1:0] last_x_reg;
    logic signed [COORD_W-1:0] last_y_reg;
    logic [RANGE_W-1:0]        last_range_reg;
    logic [ANGLE_W-1:0]        last_angle_reg;
    logic                      seen_reg;

    logic [ANGLE_W-1:0] dtheta;
    logic [ANGLE_W:0]   half_d;
    logic [31:0]        scaled;
    logic [31:0]        idx_wide;

    assign points.ready = !full;
    assign push         = points.valid && points.ready;

    // A point opens a scan when flagged, or when no point came since reset.
    assign step.first = points.scan_start || !seen_reg;
    assign step.dx    = {points.point_x_mm[COORD_W-1], points.point_x_mm}
                      - {last_x_reg[COORD_W-1], last_x_reg};
    assign step.dy    = {points.point_y_mm[COORD_W-1], points.point_y_mm}
                      - {last_y_reg[COORD_W-1], last_y_reg};
    assign step.min_range = (last_range_reg < points.range_mm) ? last_range_reg
                                                                : points.range_mm;

    // Fold the angle step onto a half turn and scale it to a table index.
    always_comb
    begin
        dtheta   = points.angle_units - last_angle_reg;
        half_d   = dtheta[ANGLE_W-1] ? ((ANGLE_W + 1)'(1 << ANGLE_W) - {1'b0, dtheta})
                                     : {1'b0, dtheta};
        scaled   = 32'(half_d) * 32'(SINE_TABLE_DEPTH) + 32'd16384;
        idx_wide = scaled >> 15;
        if (idx_wide > 32'(SINE_TABLE_DEPTH - 1))
            step_idx = IDX_W'(SINE_TABLE_DEPTH - 1);
        else
            step_idx = idx_wide[IDX_W-1:0];
    end

    // Previous point, updated by every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_range_reg <= '0;
            last_angle_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else if (push)
        begin
            last_x_reg     <= points.point_x_mm;
            last_y_reg     <= points.point_y_mm;
            last_range_reg <= points.range_mm;
            last_angle_reg <= points.angle_units;
            seen_reg       <= 1'b1;
        end
    end

endmodule

// ===== sv/ads_back.sv =====
module ads_back
    import ads_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = ads_pkg::SINE_TABLE_DEPTH,
    parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [GAP_W-1:0] cfg_wdata,
    input  logic             empty,
    input  ads_step_t        head_step,
    input  logic [IDX_W-1:0] head_idx,
    output logic             pop,
    ads_cluster_if.source    clusters
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SINE,
        S_THRESH,
        S_SQ_DX,
        S_SQ_DY,
        S_COMPARE,
        S_EMIT
    } state_t;

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Quarter-wave sine table, filled at elaboration.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    a;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            a      = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
            rom[i] = sine_entry(a);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    state_t                    state_reg;
    logic [GAP_W-1:0]          base_gap_reg;
    logic [CLUSTER_W-1:0]      count_reg;
    logic [SINE_W-1:0]         sine_reg;
    logic                      first_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic [RANGE_W-1:0]        min_range_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [37:0]               acc_reg;
    logic                      brk_reg;
    logic signed [39:0]        prod_reg;
    logic                      out_valid_reg;
    logic [CLUSTER_W-1:0]      out_number_reg;
    logic                      out_opens_reg;

    logic signed [19:0] mul_a;
    logic signed [19:0] mul_b;
    logic [32:0]        rounded;
    logic [19:0]        thr_sum;
    logic [CLUSTER_W-1:0] count_next;
    logic               out_free;

    assign clusters.valid          = out_valid_reg;
    assign clusters.cluster_number = out_number_reg;
    assign clusters.opens_cluster  = out_opens_reg;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign out_free = !out_valid_reg || clusters.ready;

    // Operand select for the one shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_MUL_SINE:
            begin
                mul_a = {5'b0, sine_reg};
                mul_b = {3'b0, min_range_reg};
            end
            S_THRESH:
            begin
                mul_a = {dx_reg[DIFF_W-1], dx_reg};
                mul_b = {dx_reg[DIFF_W-1], dx_reg};
            end
            S_SQ_DX:
            begin
                mul_a = {dy_reg[DIFF_W-1], dy_reg};
                mul_b = {dy_reg[DIFF_W-1], dy_reg};
            end
            S_SQ_DY:
            begin
                mul_a = {2'b0, thr_reg};
                mul_b = {2'b0, thr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Threshold from the scaled sine product, saturated.
    always_comb
    begin
        rounded = {1'b0, prod_reg[31:0]} + 33'd8192;
        thr_sum = {4'b0, base_gap_reg} + {1'b0, rounded[32:14]};
    end

    // Cluster number for the result about to leave.
    always_comb
    begin
        if (first_reg)
            count_next = CLUSTER_W'(1);
        else if (brk_reg && (count_reg < CLUSTER_CAP))
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
    end

    // Sine table read, one registered port.
    always_ff @(posedge clk)
    begin
        if (pop)
            sine_reg <= SINE_ROM[head_idx];
    end

    // Sequencer datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (pop)
        begin
            first_reg     <= head_step.first;
            dx_reg        <= head_step.dx;
            dy_reg        <= head_step.dy;
            min_range_reg <= head_step.min_range;
        end
        if (state_reg == S_THRESH)
            thr_reg <= (thr_sum > {2'b0, THR_MAX}) ? THR_MAX : thr_sum[THR_W-1:0];
        if (state_reg == S_SQ_DX)
            acc_reg <= {1'b0, prod_reg[36:0]};
        if (state_reg == S_SQ_DY)
            acc_reg <= acc_reg + {1'b0, prod_reg[36:0]};
        if (state_reg == S_COMPARE)
            brk_reg <= (acc_reg > {1'b0, prod_reg[36:0]});
    end

    // State, cluster count, threshold register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_gap_reg   <= GAP_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_number_reg <= '0;
            out_opens_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                base_gap_reg <= cfg_wdata;
            // The result register empties when taken, unless a new result replaces it.
            if (out_valid_reg && clusters.ready && !((state_reg == S_EMIT) && out_free))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                        state_reg <= head_step.first ? S_EMIT : S_MUL_SINE;
                end
                S_MUL_SINE: state_reg <= S_THRESH;
                S_THRESH:   state_reg <= S_SQ_DX;
                S_SQ_DX:    state_reg <= S_SQ_DY;
                S_SQ_DY:    state_reg <= S_COMPARE;
                S_COMPARE:  state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_number_reg <= count_next;
                        out_opens_reg  <= first_reg || brk_reg;
                        count_reg      <= count_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/ads_checker.sv =====
module ads_checker
    import ads_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [CLUSTER_W-1:0] out_number,
    input logic                 out_opens
);

    logic                 out_fire;
    logic                 have_prev_reg;
    logic [CLUSTER_W-1:0] prev_reg;

    assign out_fire = out_valid && out_ready;

    // Last delivered cluster number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else if (out_fire)
        begin
            have_prev_reg <= 1'b1;
            prev_reg      <= out_number;
        end
    end

    // A stalled result request keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_number) && $stable(out_opens))
        else $error("result changed while stalled");

    // Cluster numbers stay between one and the cap.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_number != '0) && (out_number <= CLUSTER_CAP))
        else $error("cluster number out of range");

    // A point that does not open a cluster keeps the previous number.
    a_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_opens |-> have_prev_reg && (out_number == prev_reg))
        else $error("cluster number changed without a break");

    // A break inside a scan advances the number by one, or holds it at the cap.
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_opens && (out_number != CLUSTER_W'(1)) |->
            have_prev_reg && ((out_number == prev_reg + 1'b1) || (out_number == prev_reg)))
        else $error("cluster number did not advance on a break");

endmodule

bind adaptive_distance_scan_segmenter ads_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (clusters.valid),
    .out_ready  (clusters.ready),
    .out_number (clusters.cluster_number),
    .out_opens  (clusters.opens_cluster)
);
